/* sv/kbt_pkg.sv */
// Shared types, constants and helper functions for the keyed block transposition block.
// No dependencies; every other file in sv/ imports this package.
package kbt_pkg;

  localparam int MAX_BLOCK  = 8;
  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = 3;
  localparam int CNT_W      = 4;
  localparam int KEY_W      = MAX_BLOCK * ADDR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = KEY_W;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KEY_W-1:0]  key_t;

  localparam char_t PAD_CHAR   = 8'h7A;
  localparam char_t SPACE_CHAR = 8'h20;
  localparam char_t LOWER_A    = 8'h61;
  localparam char_t LOWER_Z    = 8'h7A;
  localparam char_t CASE_DELTA = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_PERM   = 2'd2;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  localparam cnt_t RST_BLOCK_SIZE = 4'd8;
  localparam key_t RST_KEY_PERM   = 24'hFAC688;

  // Read-side tags that travel with one buffer read.
  typedef struct packed {
    logic pad;   // position lies past the fill of a short final block
    logic last;  // final beat of this block
    logic done;  // final beat of the message
  } rd_meta_t;

  // Key entry k, clamped below the effective block size.
  function automatic addr_t key_at(key_t key, addr_t k, cnt_t size);
    addr_t v;
    v = key[k*ADDR_W +: ADDR_W];
    if ({1'b0, v} >= size) begin
      v = ADDR_W'(size - cnt_t'(1));
    end
    return v;
  endfunction

  function automatic char_t to_upper(char_t c);
    char_t r;
    r = c;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

endpackage

/* sv/kbt_buf_mem.sv */
// Block buffer: one-write, one-read synchronous memory with registered read data.
// Depends on kbt_pkg for widths.
module kbt_buf_mem (
  input  logic          clk,
  input  logic          we,
  input  kbt_pkg::addr_t waddr,
  input  kbt_pkg::char_t wdata,
  input  logic          re,
  input  kbt_pkg::addr_t raddr,
  output kbt_pkg::char_t rdata
);
  import kbt_pkg::*;

  char_t mem [MAX_BLOCK];
  char_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/kbt_seq.sv */
// Input acceptance, fill count and emission sequencer with permuted read addressing.
// Depends on kbt_pkg; drives kbt_buf_mem and feeds read tags to kbt_out.
module kbt_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  kbt_pkg::char_t     in_char,
  input  logic               in_end,
  input  logic               in_char_valid,
  input  logic               direction,
  input  kbt_pkg::cnt_t      size,
  input  kbt_pkg::key_t      key,
  input  logic               pipe_ready,
  output logic               mem_we,
  output kbt_pkg::addr_t     mem_waddr,
  output kbt_pkg::char_t     mem_wdata,
  output logic               rd_en,
  output kbt_pkg::addr_t     rd_addr,
  output kbt_pkg::rd_meta_t  rd_meta
);
  import kbt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic  state_r, state_nxt;
  addr_t fill_r, fill_nxt;
  addr_t pos_r, pos_nxt;
  addr_t last_idx_r, last_idx_nxt;
  cnt_t  blk_fill_r, blk_fill_nxt;
  logic  done_r, done_nxt;

  logic  accept;
  logic  store;
  cnt_t  new_fill;
  logic  emit;
  addr_t src;
  logic  is_last;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign store     = in_char_valid && !(direction == DIR_ENCRYPT && in_char == SPACE_CHAR);
  assign new_fill  = {1'b0, fill_r} + (store ? cnt_t'(1) : cnt_t'(0));
  assign emit      = (new_fill >= size) || (in_end && new_fill != cnt_t'(0));

  assign mem_we    = accept && store;
  assign mem_waddr = fill_r;
  assign mem_wdata = in_char;

  // Source position for output position pos_r; decrypt takes the last key hit.
  always_comb begin
    src = pos_r;
    if (direction == DIR_ENCRYPT) begin
      src = key_at(key, pos_r, size);
    end else begin
      for (int k = 0; k < MAX_BLOCK; k++) begin
        if (cnt_t'(k) < size && key_at(key, ADDR_W'(k), size) == pos_r) begin
          src = ADDR_W'(k);
        end
      end
    end
  end

  assign is_last      = (pos_r == last_idx_r);
  assign rd_en        = (state_r == ST_EMIT) && pipe_ready;
  assign rd_addr      = src;
  assign rd_meta.pad  = ({1'b0, src} >= blk_fill_r);
  assign rd_meta.last = is_last;
  assign rd_meta.done = is_last && done_r;

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    pos_nxt      = pos_r;
    last_idx_nxt = last_idx_r;
    blk_fill_nxt = blk_fill_r;
    done_nxt     = done_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (emit) begin
            state_nxt    = ST_EMIT;
            fill_nxt     = '0;
            pos_nxt      = '0;
            last_idx_nxt = ADDR_W'(size - cnt_t'(1));
            blk_fill_nxt = new_fill;
            done_nxt     = in_end;
          end else begin
            fill_nxt = ADDR_W'(new_fill);
          end
        end
      end
      ST_EMIT: begin
        if (rd_en) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r + addr_t'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_idx_r <= last_idx_nxt;
    blk_fill_r <= blk_fill_nxt;
    done_r     <= done_nxt;
  end

endmodule

/* sv/kbt_out.sv */
// Read-data stage and output register: pad substitution, upper-casing, stall handling.
// Depends on kbt_pkg; takes read tags from kbt_seq and data from kbt_buf_mem.
module kbt_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  kbt_pkg::rd_meta_t rd_meta,
  input  kbt_pkg::char_t    rdata,
  output logic              pipe_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output kbt_pkg::char_t    out_char,
  output logic              out_last,
  output logic              out_done
);
  import kbt_pkg::*;

  logic     rd_v_r, rd_v_nxt;
  rd_meta_t meta_r;
  logic     oval_r, oval_nxt;
  char_t    ochar_r;
  logic     olast_r;
  logic     odone_r;
  logic     move;
  char_t    cval;

  // Advance the read stage into the output register when it is free or draining.
  assign move       = rd_v_r && (!oval_r || out_tready);
  assign pipe_ready = !rd_v_r || move;
  assign cval       = to_upper(meta_r.pad ? PAD_CHAR : rdata);

  always_comb begin
    rd_v_nxt = rd_v_r;
    if (rd_en) begin
      rd_v_nxt = 1'b1;
    end else if (move) begin
      rd_v_nxt = 1'b0;
    end
    oval_nxt = oval_r;
    if (move) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      rd_v_r <= rd_v_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      meta_r <= rd_meta;
    end
    if (move) begin
      ochar_r <= cval;
      olast_r <= meta_r.last;
      odone_r <= meta_r.done;
    end
  end

  assign out_tvalid = oval_r;
  assign out_char   = ochar_r;
  assign out_last   = olast_r;
  assign out_done   = odone_r;

endmodule

/* sv/keyed_block_transposition_top.sv */
// Top level of the keyed block transposition block: configuration registers and wiring.
// Depends on kbt_pkg, kbt_buf_mem, kbt_seq and kbt_out.
//
//  Channel  Direction  Handshake            Content
//  in_      slave      in_tvalid/in_tready  tdata=char_in, tlast=message_end, tuser=char_valid
//  out_     master     out_tvalid/tready    tdata=char_out, tlast=block_last, tuser=message_done
//  cfg_     write      cfg_we               cfg_index selects register, cfg_wdata value
//
// A beat that completes a block (full, or message end with bytes held) holds in_tready
// low until the last byte of that block is read; the sequencer reads one permuted byte per
// cycle while pipe_ready is high from the buffer memory's single read port, and output
// bytes pass through the registered read data and then the output register.
// Reset (rst_n low, synchronous) clears the fill count, the sequencer and the output
// valids and loads the register defaults; the buffer memory is not cleared.
// A stall on out_tready holds the read stage and then the reads; nothing is dropped.
module keyed_block_transposition_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] char_in
  input  logic                           in_tlast,
  input  logic                           in_tuser,   // [0] char_valid
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] char_out
  output logic                           out_tlast,
  output logic                           out_tuser,  // [0] message_done
  input  logic                           cfg_we,
  input  logic [kbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kbt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kbt_pkg::*;

  logic     direction_r;
  cnt_t     block_size_r;
  key_t     key_r;
  cnt_t     eff_size;

  logic     mem_we;
  addr_t    mem_waddr;
  char_t    mem_wdata;
  logic     rd_en;
  addr_t    rd_addr;
  char_t    rdata;
  rd_meta_t rd_meta;
  logic     pipe_ready;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= DIR_ENCRYPT;
      block_size_r <= RST_BLOCK_SIZE;
      key_r        <= RST_KEY_PERM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION:  direction_r  <= cfg_wdata[0];
        CFG_BLOCK_SIZE: block_size_r <= cfg_wdata[CNT_W-1:0];
        CFG_KEY_PERM:   key_r        <= cfg_wdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; saturate at the buffer depth.
  always_comb begin
    eff_size = block_size_r;
    if (block_size_r == cnt_t'(0)) begin
      eff_size = cnt_t'(1);
    end else if (block_size_r > cnt_t'(MAX_BLOCK)) begin
      eff_size = cnt_t'(MAX_BLOCK);
    end
  end

  kbt_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_char       (in_tdata),
    .in_end        (in_tlast),
    .in_char_valid (in_tuser),
    .direction     (direction_r),
    .size          (eff_size),
    .key           (key_r),
    .pipe_ready    (pipe_ready),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_meta       (rd_meta)
  );

  kbt_buf_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  kbt_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (rd_en),
    .rd_meta    (rd_meta),
    .rdata      (rdata),
    .pipe_ready (pipe_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast),
    .out_done   (out_tuser)
  );

endmodule
